FILE: rtl/per_port_token_bucket_policer_core_assert.svh
// Assertion macros shared by the checker of the policer core.
// Depends on nothing; each macro expands to one clocked concurrent assertion.
`ifndef PER_PORT_TOKEN_BUCKET_POLICER_CORE_ASSERT_SVH
`define PER_PORT_TOKEN_BUCKET_POLICER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPBP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PPBP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ppbp_pkg.sv
// Shared types and constants of the per-port token bucket policer.
// Used by every module of the block; depends on nothing.
package ppbp_pkg;

  localparam int PORT_W     = 16;
  localparam int LEN_W      = 16;
  localparam int TIME_W     = 32;
  localparam int RATE_W     = 16;
  localparam int LEVEL_W    = 24;
  localparam int VERDICT_W  = 17;
  localparam int MS_PER_S   = 1000;
  localparam int SEC_W      = 23;
  localparam int MS_W       = 10;
  localparam int RCP_W      = 29;
  localparam int RCP_SHIFT  = 38;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int QDEPTH     = 2;

  localparam int FLOW_COUNT_DEF = 65536;

  localparam logic [RCP_W-1:0]   RCP_MS       = 29'd274877907;
  localparam logic [RATE_W-1:0]  RATE_RESET   = 16'd5000;
  localparam logic [LEVEL_W-1:0] BURST_RESET  = 24'd3000;
  localparam logic [LEVEL_W-1:0] THRESH_RESET = 24'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REFILL_RATE    = 2'd0,
    CFG_BURST_LIMIT    = 2'd1,
    CFG_DROP_THRESHOLD = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [PORT_W-1:0] source_port;
    logic [PORT_W-1:0] dest_port;
    logic [LEN_W-1:0]  datagram_length;
    logic [TIME_W-1:0] time_ms;
  } in_t;

  typedef struct packed {
    logic                 pass;
    logic [VERDICT_W-1:0] verdict;
    logic [LEVEL_W-1:0]   tokens_left;
  } out_t;

  typedef struct packed {
    logic [RATE_W-1:0]  refill_rate;
    logic [LEVEL_W-1:0] burst_limit;
    logic [LEVEL_W-1:0] drop_threshold;
  } cfg_t;

  typedef struct packed {
    logic [PORT_W-1:0]    slot;
    logic [VERDICT_W-1:0] verdict;
    logic [LEN_W-1:0]     length;
    logic [TIME_W-1:0]    time_ms;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [TIME_W-1:0]  stamp;
  } bucket_t;

endpackage

FILE: rtl/ppbp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on ppbp_pkg for its default depth.
module ppbp_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = ppbp_pkg::FLOW_COUNT_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ppbp_front.sv
// Front end: accepts datagram headers, reduces the source port to a table slot
// and forms the pass verdict, then pushes the item into the queue. Uses ppbp_pkg.
module ppbp_front #(
  parameter int FLOW_COUNT = ppbp_pkg::FLOW_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              hold_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ppbp_pkg::in_t     in_data_i,
  input  ppbp_pkg::q_stat_t q_stat_i,
  output logic              push_o,
  output ppbp_pkg::item_t   push_data_o
);

  localparam int IDX_W = $clog2(FLOW_COUNT);
  localparam int PW    = ppbp_pkg::PORT_W;
  localparam int MP_W  = PW + 32;
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(FLOW_COUNT) + 64'd1);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MOD  = 4'b0010,
    F_RED  = 4'b0100,
    F_PUSH = 4'b1000
  } front_state_e;

  front_state_e       state_q, state_d;
  logic [PW-1:0]      shf_q, shf_d;
  logic [PW-1:0]      quot_q, quot_d;
  logic [IDX_W-1:0]   rem_q, rem_d;
  ppbp_pkg::item_t    item_q, item_d;
  logic [MP_W-1:0]    quot_mul;
  logic [31:0]        back_mul;
  logic [PW-1:0]      rem_full;
  logic               accept;

  assign in_stall_o = hold_i || (state_q != F_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign quot_mul   = MP_W'(shf_q) * MP_W'(RECIP);
  assign back_mul   = 32'(quot_q) * 32'(FLOW_COUNT);
  assign rem_full   = shf_q - back_mul[PW-1:0];

  always_comb begin
    push_data_o      = item_q;
    push_data_o.slot = ppbp_pkg::PORT_W'(rem_q);
  end

  always_comb begin
    state_d = state_q;
    shf_d   = shf_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    item_d  = item_q;
    push_o  = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          shf_d          = in_data_i.source_port;
          rem_d          = '0;
          item_d.slot    = '0;
          item_d.verdict = {1'b0, in_data_i.source_port} + {1'b0, in_data_i.dest_port};
          item_d.length  = in_data_i.datagram_length;
          item_d.time_ms = in_data_i.time_ms;
          state_d        = F_MOD;
        end
      end
      F_MOD: begin
        quot_d  = quot_mul[MP_W-1:32];
        state_d = F_RED;
      end
      F_RED: begin
        rem_d   = rem_full[IDX_W-1:0];
        state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!q_stat_i.full) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shf_q  <= shf_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
    item_q <= item_d;
  end

endmodule

FILE: rtl/ppbp_fifo.sv
// Short queue between the front end and the back end of the policer.
// Holds classified items; depth and item type come from ppbp_pkg.
module ppbp_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ppbp_pkg::item_t   push_data_i,
  input  logic              pop_i,
  output ppbp_pkg::item_t   pop_data_o,
  output ppbp_pkg::q_stat_t stat_o
);

  localparam int PTR_W = $clog2(ppbp_pkg::QDEPTH);
  localparam int CNT_W = $clog2(ppbp_pkg::QDEPTH + 1);

  ppbp_pkg::item_t  mem_q [ppbp_pkg::QDEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign pop_data_o   = mem_q[rptr_q];
  assign stat_o.full  = (cnt_q == CNT_W'(ppbp_pkg::QDEPTH));
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

FILE: rtl/ppbp_back.sv
// Back end: per-flow read-modify-write of the bucket tables, refill through
// multiplications by the reciprocal of 1000, drop decision and output
// register. Uses ppbp_pkg and ppbp_ram.
module ppbp_back #(
  parameter int FLOW_COUNT = ppbp_pkg::FLOW_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ppbp_pkg::cfg_t    cfg_i,
  input  ppbp_pkg::q_stat_t q_stat_i,
  output logic              pop_o,
  input  ppbp_pkg::item_t   pop_data_i,
  output logic              clearing_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ppbp_pkg::out_t    out_data_o
);

  localparam int IDX_W   = $clog2(FLOW_COUNT);
  localparam int BKT_W   = $bits(ppbp_pkg::bucket_t);
  localparam int TIME_W  = ppbp_pkg::TIME_W;
  localparam int RATE_W  = ppbp_pkg::RATE_W;
  localparam int LVL_W   = ppbp_pkg::LEVEL_W;
  localparam int SEC_W   = ppbp_pkg::SEC_W;
  localparam int MS_W    = ppbp_pkg::MS_W;
  localparam int WHOLE_W = SEC_W + RATE_W;
  localparam int FRAC_W  = MS_W + RATE_W;
  localparam int SUM_W   = WHOLE_W + 1;
  localparam int RPROD_W = TIME_W + ppbp_pkg::RCP_W;
  localparam int RSH     = ppbp_pkg::RCP_SHIFT;

  typedef enum logic [9:0] {
    B_CLEAR = 10'b0000000001,
    B_IDLE  = 10'b0000000010,
    B_READ  = 10'b0000000100,
    B_LOAD  = 10'b0000001000,
    B_DIV   = 10'b0000010000,
    B_REM   = 10'b0000100000,
    B_FRAC  = 10'b0001000000,
    B_FDIV  = 10'b0010000000,
    B_CALC  = 10'b0100000000,
    B_FIN   = 10'b1000000000
  } back_state_e;

  back_state_e                     state_q, state_d;
  logic [IDX_W-1:0]                clr_q, clr_d;
  ppbp_pkg::item_t                 item_q, item_d;
  logic                            seen_q, seen_d;
  logic [LVL_W-1:0]                level_q, level_d;
  logic [TIME_W-1:0]               elap_q, elap_d;
  logic [SEC_W-1:0]                secs_q, secs_d;
  logic [MS_W-1:0]                 msr_q, msr_d;
  logic [WHOLE_W-1:0]              whole_q, whole_d;
  logic [FRAC_W-1:0]               fprod_q, fprod_d;
  logic [RATE_W-1:0]               frac_q, frac_d;
  logic [LVL_W-1:0]                lvl_q, lvl_d;
  logic                            out_valid_q, out_valid_d;
  ppbp_pkg::out_t                  out_q, out_d;

  logic                            seen_we, bkt_we, rd_en;
  logic [IDX_W-1:0]                slot, seen_waddr;
  logic                            seen_wdata, seen_rd;
  logic [BKT_W-1:0]                bkt_rd_raw;
  ppbp_pkg::bucket_t               bkt_rd, bkt_wr;
  logic [TIME_W-1:0]               elapsed;
  logic [RPROD_W-1:0]              secs_mul;
  logic [TIME_W-1:0]               secs_ms;
  logic [TIME_W-1:0]               ms_left;
  logic [RPROD_W-1:0]              frac_mul;
  logic [SUM_W-1:0]                sum;
  logic                            drop;
  logic [LVL_W-1:0]                len_ext, new_lvl;
  logic                            fin_go;

  assign slot       = item_q.slot[IDX_W-1:0];
  assign rd_en      = (state_q == B_READ);
  assign clearing_o = (state_q == B_CLEAR);
  assign fin_go     = (state_q == B_FIN) && (!out_valid_q || !out_stall_i);

  assign seen_we    = clearing_o || fin_go;
  assign seen_waddr = clearing_o ? clr_q : slot;
  assign seen_wdata = !clearing_o;
  assign bkt_we     = fin_go;

  assign bkt_rd   = bkt_rd_raw;
  assign elapsed  = item_q.time_ms - bkt_rd.stamp;
  assign secs_mul = RPROD_W'(elap_q) * RPROD_W'(ppbp_pkg::RCP_MS);
  assign secs_ms  = TIME_W'(secs_q) * TIME_W'(ppbp_pkg::MS_PER_S);
  assign ms_left  = elap_q - secs_ms;
  assign frac_mul = RPROD_W'(fprod_q) * RPROD_W'(ppbp_pkg::RCP_MS);
  assign sum      = SUM_W'(level_q) + SUM_W'(whole_q) + SUM_W'(frac_q);

  assign len_ext = LVL_W'(item_q.length);
  assign drop    = (lvl_q <= cfg_i.drop_threshold);
  assign new_lvl = drop ? lvl_q : ((lvl_q > len_ext) ? (lvl_q - len_ext) : '0);

  assign bkt_wr.level = new_lvl;
  assign bkt_wr.stamp = item_q.time_ms;

  ppbp_ram #(
    .WIDTH (1),
    .DEPTH (FLOW_COUNT)
  ) u_seen_ram (
    .clk_i   (clk_i),
    .we_i    (seen_we),
    .waddr_i (seen_waddr),
    .wdata_i (seen_wdata),
    .re_i    (rd_en),
    .raddr_i (slot),
    .rdata_o (seen_rd)
  );

  ppbp_ram #(
    .WIDTH (BKT_W),
    .DEPTH (FLOW_COUNT)
  ) u_bucket_ram (
    .clk_i   (clk_i),
    .we_i    (bkt_we),
    .waddr_i (slot),
    .wdata_i (bkt_wr),
    .re_i    (rd_en),
    .raddr_i (slot),
    .rdata_o (bkt_rd_raw)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    item_d      = item_q;
    seen_d      = seen_q;
    level_d     = level_q;
    elap_d      = elap_q;
    secs_d      = secs_q;
    msr_d       = msr_q;
    whole_d     = whole_q;
    fprod_d     = fprod_q;
    frac_d      = frac_q;
    lvl_d       = lvl_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    pop_o       = 1'b0;
    case (state_q)
      B_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == IDX_W'(FLOW_COUNT - 1)) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o   = 1'b1;
          item_d  = pop_data_i;
          state_d = B_READ;
        end
      end
      B_READ: begin
        state_d = B_LOAD;
      end
      B_LOAD: begin
        seen_d  = seen_rd;
        level_d = bkt_rd.level;
        elap_d  = elapsed;
        state_d = seen_rd ? B_DIV : B_CALC;
      end
      B_DIV: begin
        secs_d  = secs_mul[RSH +: SEC_W];
        state_d = B_REM;
      end
      B_REM: begin
        msr_d   = ms_left[MS_W-1:0];
        whole_d = WHOLE_W'(secs_q) * WHOLE_W'(cfg_i.refill_rate);
        state_d = B_FRAC;
      end
      B_FRAC: begin
        fprod_d = FRAC_W'(msr_q) * FRAC_W'(cfg_i.refill_rate);
        state_d = B_FDIV;
      end
      B_FDIV: begin
        frac_d  = frac_mul[RSH +: RATE_W];
        state_d = B_CALC;
      end
      B_CALC: begin
        if (!seen_q || (sum > SUM_W'(cfg_i.burst_limit))) begin
          lvl_d = cfg_i.burst_limit;
        end else begin
          lvl_d = sum[LVL_W-1:0];
        end
        state_d = B_FIN;
      end
      B_FIN: begin
        if (fin_go) begin
          out_d.pass        = !drop;
          out_d.verdict     = drop ? '0 : item_q.verdict;
          out_d.tokens_left = new_lvl;
          out_valid_d       = 1'b1;
          state_d           = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    seen_q  <= seen_d;
    level_q <= level_d;
    elap_q  <= elap_d;
    secs_q  <= secs_d;
    msr_q   <= msr_d;
    whole_q <= whole_d;
    fprod_q <= fprod_d;
    frac_q  <= frac_d;
    lvl_q   <= lvl_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/per_port_token_bucket_policer_core.sv
// Top level of the per-port token bucket policer: configuration registers and
// the front end, queue and back end. Uses ppbp_pkg, ppbp_front, ppbp_fifo, ppbp_back.
//
// Usage. Datagram headers enter on the in channel (in_valid_i, in_stall_o,
// in_data_i) and one verdict per header leaves on the out channel
// (out_valid_o, out_stall_i, out_data_o), in arrival order. A beat moves when
// valid is high and stall is low. Registers are to be written over the cfg
// channel (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i) only while the
// block is idle; the user is bound to this and the block does not enforce it.
// cfg_ready_o is always high and unknown indexes are ignored. The front end
// takes one header at a time, reducing the source port to a table slot with a
// reciprocal multiplication, and takes the next header only after it has
// pushed the item, which waits while the queue is full. The back end takes
// one item at a time; for a known flow it runs the two reciprocal divisions
// by 1000 of the refill, which a flow seen for the first time skips. A
// two-entry queue lets both ends work at once. After reset the seen flags are
// cleared one entry per cycle, and in_stall_o stays high until that pass ends.
// When the receiver stalls, the result waits in the output register and the
// back end holds the next item until the register is free.
module per_port_token_bucket_policer_core #(
  parameter int FLOW_COUNT = ppbp_pkg::FLOW_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  ppbp_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output ppbp_pkg::out_t                out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ppbp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ppbp_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  ppbp_pkg::cfg_t    cfg_q, cfg_d;
  ppbp_pkg::q_stat_t q_stat;
  ppbp_pkg::item_t   push_data, pop_data;
  logic              push, pop, clearing;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        ppbp_pkg::CFG_REFILL_RATE: begin
          cfg_d.refill_rate = cfg_data_i[ppbp_pkg::RATE_W-1:0];
        end
        ppbp_pkg::CFG_BURST_LIMIT: begin
          cfg_d.burst_limit = cfg_data_i[ppbp_pkg::LEVEL_W-1:0];
        end
        ppbp_pkg::CFG_DROP_THRESHOLD: begin
          cfg_d.drop_threshold = cfg_data_i[ppbp_pkg::LEVEL_W-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.refill_rate    <= ppbp_pkg::RATE_RESET;
      cfg_q.burst_limit    <= ppbp_pkg::BURST_RESET;
      cfg_q.drop_threshold <= ppbp_pkg::THRESH_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ppbp_front #(
    .FLOW_COUNT (FLOW_COUNT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hold_i      (clearing),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  ppbp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  ppbp_back #(
    .FLOW_COUNT (FLOW_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .pop_data_i  (pop_data),
    .clearing_o  (clearing),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: rtl/ppbp_checker.sv
// Port-level checker of the policer core, bound to the top level.
// Depends on ppbp_pkg and the assertion macros header.
`include "per_port_token_bucket_policer_core_assert.svh"

module ppbp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input ppbp_pkg::in_t                   in_data_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input ppbp_pkg::out_t                  out_data_o,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o
);

  `PPBP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                   out_valid_o && $stable(out_data_o),
                   "Stalled result beat changed or vanished.")

  `PPBP_ASSERT_NXT(a_in_hold, clk_i, rst_ni, in_valid_i && in_stall_o,
                   in_valid_i && $stable(in_data_i),
                   "Stalled header beat changed or vanished.")

  `PPBP_ASSERT_IMP(a_clear_after_reset, clk_i, rst_ni, $rose(rst_ni), in_stall_o,
                   "Input taken before the seen flags were cleared.")

  `PPBP_ASSERT_NXT(a_one_header_at_a_time, clk_i, rst_ni, in_valid_i && !in_stall_o,
                   in_stall_o, "Front end took a header while classifying another.")

  `PPBP_ASSERT_IMP(a_cfg_ready, clk_i, rst_ni, cfg_valid_i, cfg_ready_o,
                   "Register write was refused.")

endmodule

bind per_port_token_bucket_policer_core ppbp_checker u_ppbp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);
